[rtl/core/lldak_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, state codes and the key-to-seen-map index function
// for the linked list duplicate removal unit. No dependencies.
package lldak_pkg;

  // Field widths of the request and result ports.
  localparam int ACT_W    = 2;
  localparam int ADDR_W   = 10;
  localparam int KEY_W    = 13;
  localparam int LINK_W   = 11;

  // Node table, walk limit and seen map sizing.
  localparam int NODE_COUNT   = 1 << ADDR_W;
  localparam int DEPTH        = 1024;
  localparam int WALK_LIMIT   = (DEPTH < NODE_COUNT) ? DEPTH : NODE_COUNT;
  localparam int CNT_W        = ADDR_W + 1;
  localparam int KEY_MAG_BITS = 12;
  localparam int SEEN_SIZE    = 1 << KEY_MAG_BITS;
  localparam int EPOCH_W      = 8;

  // Request codes.
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // Controller state codes.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] S_CLEAR   = 3'd1;
  localparam logic [ST_W-1:0] S_NODE_RD = 3'd2;
  localparam logic [ST_W-1:0] S_SEEN_RD = 3'd3;
  localparam logic [ST_W-1:0] S_UPDATE  = 3'd4;
  localparam logic [ST_W-1:0] S_RD_NEXT = 3'd5;
  localparam logic [ST_W-1:0] S_RD_OUT  = 3'd6;

  typedef logic [KEY_MAG_BITS-1:0] seen_idx_t;

  // Absolute key value, saturated to the last seen map entry.
  function automatic seen_idx_t seen_index(input logic signed [KEY_W-1:0] key);
    logic signed [KEY_W:0] kx;
    logic        [KEY_W:0] mag;
    kx  = (KEY_W+1)'(key);
    mag = kx[KEY_W] ? (KEY_W+1)'(-kx) : (KEY_W+1)'(kx);
    if (mag >= (KEY_W+1)'(SEEN_SIZE - 1)) begin
      return seen_idx_t'(SEEN_SIZE - 1);
    end
    return mag[KEY_MAG_BITS-1:0];
  endfunction

endpackage

[rtl/core/lldak_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// Self-contained; used for the node table, seen map and order list.
module lldak_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:(1<<AW)-1];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/linked_list_dedup_abs_key_unit.sv]
`timescale 1ns / 1ps
// Top level of the linked list duplicate removal unit: controller and memories.
// Depends on lldak_pkg and lldak_ram.
//
// Usage. A request is taken when start is high and busy is low. in_action
// selects it: load writes in_node_key and in_link_addr at in_node_addr when
// taken; start walks the list from the head in_node_addr; read emits the next
// node of the kept list, then of the deleted list, with its relinked next link.
// A walk marks each absolute key in a seen map. The map entries carry an epoch
// tag, so a start normally costs nothing extra; every 255th start, and after
// reset, a clearing pass over all 4096 entries sweeps the map first.
// A walk takes three steps per node (node table read, seen map read, update),
// as both memories have a registered read. A read passes through order list,
// next entry and key lookups, and its result is then registered onto the out_
// ports, marked by out_valid for exactly one cycle; the next request may be
// taken in that same cycle.
// A read past the end of both lists gives no result and busy stays low.
// Reset (rst_n low, synchronous) clears the counts and starts the clearing
// pass; busy is high until it ends. The receiver cannot stall results.
module linked_list_dedup_abs_key_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lldak_pkg::ACT_W-1:0]          in_action,
  input  logic [lldak_pkg::ADDR_W-1:0]         in_node_addr,
  input  logic signed [lldak_pkg::KEY_W-1:0]   in_node_key,
  input  logic signed [lldak_pkg::LINK_W-1:0]  in_link_addr,
  output logic                                 out_valid,
  output logic                                 out_list_id,
  output logic [lldak_pkg::ADDR_W-1:0]         out_addr,
  output logic signed [lldak_pkg::KEY_W-1:0]   out_key,
  output logic signed [lldak_pkg::LINK_W-1:0]  out_next,
  output logic                                 out_last_of_list
);

  localparam int AW   = lldak_pkg::ADDR_W;
  localparam int KW   = lldak_pkg::KEY_W;
  localparam int LW   = lldak_pkg::LINK_W;
  localparam int CW   = lldak_pkg::CNT_W;
  localparam int SW   = lldak_pkg::KEY_MAG_BITS;
  localparam int EW   = lldak_pkg::EPOCH_W;
  localparam int NW   = KW + LW;
  localparam logic [AW-1:0] ORDER_TOP = AW'(lldak_pkg::NODE_COUNT - 1);
  localparam logic [EW-1:0] EPOCH_MAX = {EW{1'b1}};
  localparam logic [EW-1:0] EPOCH_ONE = EW'(1);

  // Control registers.
  logic [lldak_pkg::ST_W-1:0] state_r, state_nxt;
  logic [CW-1:0]  kept_r, kept_nxt;
  logic [CW-1:0]  del_r, del_nxt;
  logic [CW-1:0]  rpos_r, rpos_nxt;
  logic [EW-1:0]  epoch_r, epoch_nxt;
  logic [SW-1:0]  clr_r, clr_nxt;
  logic           walk_pend_r, walk_pend_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [AW-1:0]  cur_r, cur_nxt;
  logic [LW-1:0]  link_r, link_nxt;
  logic [SW-1:0]  sidx_r, sidx_nxt;
  logic           list_r, list_nxt;
  logic           last_r, last_nxt;
  logic [AW-1:0]  idx1_r, idx1_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic           o_list_r, o_list_nxt;
  logic [AW-1:0]  o_addr_r, o_addr_nxt;
  logic [KW-1:0]  o_key_r, o_key_nxt;
  logic [LW-1:0]  o_next_r, o_next_nxt;
  logic           o_last_r, o_last_nxt;

  // Memory ports.
  logic           node_we;
  logic [AW-1:0]  node_raddr;
  logic [NW-1:0]  node_rdata;
  logic           seen_we;
  logic [SW-1:0]  seen_waddr;
  logic [EW-1:0]  seen_wdata;
  logic [SW-1:0]  seen_raddr;
  logic [EW-1:0]  seen_rdata;
  logic           order_we;
  logic [AW-1:0]  order_waddr;
  logic [AW-1:0]  order_raddr;
  logic [AW-1:0]  order_rdata;

  // Decoded fields of the node table read.
  logic signed [KW-1:0] node_key;
  logic [LW-1:0]        node_link;

  // Read request decode.
  logic [CW:0]    total;
  logic [CW-1:0]  del_pos;
  logic           rd_kept;
  logic           rd_del;
  logic [AW-1:0]  rd_idx0;
  logic           accept;
  logic           seen_hit;

  assign node_key  = $signed(node_rdata[NW-1:LW]);
  assign node_link = node_rdata[LW-1:0];
  assign accept    = start && (state_r == lldak_pkg::S_IDLE);
  assign total     = {1'b0, kept_r} + {1'b0, del_r};
  assign del_pos   = rpos_r - kept_r;
  assign rd_kept   = rpos_r < kept_r;
  assign rd_del    = {1'b0, rpos_r} < total;
  assign rd_idx0   = rd_kept ? rpos_r[AW-1:0] : ORDER_TOP - del_pos[AW-1:0];
  assign seen_hit  = seen_rdata == epoch_r;

  // Node table: key and link of every loaded node.
  lldak_ram #(.WIDTH(NW), .AW(AW)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (in_node_addr),
    .wdata ({in_node_key, in_link_addr}),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Seen map: an entry is set when it holds the current epoch.
  lldak_ram #(.WIDTH(EW), .AW(SW)) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .raddr (seen_raddr),
    .rdata (seen_rdata)
  );

  // Order list: kept nodes grow up from the bottom, deleted ones down from the top.
  lldak_ram #(.WIDTH(AW), .AW(AW)) u_order_ram (
    .clk   (clk),
    .we    (order_we),
    .waddr (order_waddr),
    .wdata (cur_r),
    .raddr (order_raddr),
    .rdata (order_rdata)
  );

  // Memory address and write enable selection.
  always_comb begin
    node_we     = accept && (in_action == lldak_pkg::ACT_LOAD);
    node_raddr  = (state_r == lldak_pkg::S_RD_NEXT) ? order_rdata : cur_r;
    seen_raddr  = lldak_pkg::seen_index(node_key);
    seen_we     = 1'b0;
    seen_waddr  = sidx_r;
    seen_wdata  = epoch_r;
    order_we    = 1'b0;
    order_waddr = seen_hit ? ORDER_TOP - del_r[AW-1:0] : kept_r[AW-1:0];
    order_raddr = (state_r == lldak_pkg::S_RD_NEXT) ? idx1_r : rd_idx0;
    if (state_r == lldak_pkg::S_CLEAR) begin
      seen_we    = 1'b1;
      seen_waddr = clr_r;
      seen_wdata = '0;
    end
    if (state_r == lldak_pkg::S_UPDATE) begin
      seen_we  = !seen_hit;
      order_we = 1'b1;
    end
  end

  // Controller next-state logic.
  always_comb begin
    state_nxt     = state_r;
    kept_nxt      = kept_r;
    del_nxt       = del_r;
    rpos_nxt      = rpos_r;
    epoch_nxt     = epoch_r;
    clr_nxt       = clr_r;
    walk_pend_nxt = walk_pend_r;
    out_valid_nxt = 1'b0;
    cur_nxt       = cur_r;
    link_nxt      = link_r;
    sidx_nxt      = sidx_r;
    list_nxt      = list_r;
    last_nxt      = last_r;
    idx1_nxt      = idx1_r;
    addr_nxt      = addr_r;
    o_list_nxt    = o_list_r;
    o_addr_nxt    = o_addr_r;
    o_key_nxt     = o_key_r;
    o_next_nxt    = o_next_r;
    o_last_nxt    = o_last_r;
    case (state_r)
      lldak_pkg::S_IDLE: begin
        if (accept && in_action == lldak_pkg::ACT_START) begin
          cur_nxt  = in_node_addr;
          kept_nxt = '0;
          del_nxt  = '0;
          rpos_nxt = '0;
          if (epoch_r == EPOCH_MAX) begin
            epoch_nxt     = EPOCH_ONE;
            clr_nxt       = '0;
            walk_pend_nxt = 1'b1;
            state_nxt     = lldak_pkg::S_CLEAR;
          end else begin
            epoch_nxt = epoch_r + EPOCH_ONE;
            state_nxt = lldak_pkg::S_NODE_RD;
          end
        end else if (accept && in_action == lldak_pkg::ACT_READ && rd_del) begin
          // Work out list, end of list and the next entry's slot up front.
          list_nxt  = !rd_kept;
          if (rd_kept) begin
            last_nxt = ({1'b0, rpos_r} + (CW+1)'(1)) >= {1'b0, kept_r};
            idx1_nxt = rpos_r[AW-1:0] + AW'(1);
          end else begin
            last_nxt = ({1'b0, del_pos} + (CW+1)'(1)) >= {1'b0, del_r};
            idx1_nxt = rd_idx0 - AW'(1);
          end
          rpos_nxt  = rpos_r + CW'(1);
          state_nxt = lldak_pkg::S_RD_NEXT;
        end
      end
      lldak_pkg::S_CLEAR: begin
        clr_nxt = clr_r + SW'(1);
        if (clr_r == {SW{1'b1}}) begin
          walk_pend_nxt = 1'b0;
          state_nxt     = walk_pend_r ? lldak_pkg::S_NODE_RD : lldak_pkg::S_IDLE;
        end
      end
      lldak_pkg::S_NODE_RD: begin
        state_nxt = lldak_pkg::S_SEEN_RD;
      end
      lldak_pkg::S_SEEN_RD: begin
        link_nxt  = node_link;
        sidx_nxt  = seen_raddr;
        state_nxt = lldak_pkg::S_UPDATE;
      end
      lldak_pkg::S_UPDATE: begin
        // First sight of a key goes to the kept list, later ones are deleted.
        if (seen_hit) begin
          del_nxt = del_r + CW'(1);
        end else begin
          kept_nxt = kept_r + CW'(1);
        end
        cur_nxt = link_r[AW-1:0];
        if (link_r[LW-1] ||
            (total + (CW+1)'(1)) >= (CW+1)'(lldak_pkg::WALK_LIMIT)) begin
          state_nxt = lldak_pkg::S_IDLE;
        end else begin
          state_nxt = lldak_pkg::S_NODE_RD;
        end
      end
      lldak_pkg::S_RD_NEXT: begin
        addr_nxt  = order_rdata;
        state_nxt = lldak_pkg::S_RD_OUT;
      end
      lldak_pkg::S_RD_OUT: begin
        out_valid_nxt = 1'b1;
        o_list_nxt    = list_r;
        o_addr_nxt    = addr_r;
        o_key_nxt     = node_rdata[NW-1:LW];
        o_next_nxt    = last_r ? {LW{1'b1}} : {1'b0, order_rdata};
        o_last_nxt    = last_r;
        state_nxt     = lldak_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lldak_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lldak_pkg::S_CLEAR;
      kept_r      <= '0;
      del_r       <= '0;
      rpos_r      <= '0;
      epoch_r     <= EPOCH_ONE;
      clr_r       <= '0;
      walk_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_r      <= kept_nxt;
      del_r       <= del_nxt;
      rpos_r      <= rpos_nxt;
      epoch_r     <= epoch_nxt;
      clr_r       <= clr_nxt;
      walk_pend_r <= walk_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    link_r   <= link_nxt;
    sidx_r   <= sidx_nxt;
    list_r   <= list_nxt;
    last_r   <= last_nxt;
    idx1_r   <= idx1_nxt;
    addr_r   <= addr_nxt;
    o_list_r <= o_list_nxt;
    o_addr_r <= o_addr_nxt;
    o_key_r  <= o_key_nxt;
    o_next_r <= o_next_nxt;
    o_last_r <= o_last_nxt;
  end

  assign busy             = state_r != lldak_pkg::S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_list_id      = o_list_r;
  assign out_addr         = o_addr_r;
  assign out_key          = $signed(o_key_r);
  assign out_next         = $signed(o_next_r);
  assign out_last_of_list = o_last_r;

  // A result only ever follows the output stage of a read.
  a_valid_after_rd_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == lldak_pkg::S_RD_OUT)
    else $error("result strobe without a completed read");

  // The two lists never hold more nodes than the order list has slots.
  a_lists_fit: assert property (@(posedge clk) disable iff (!rst_n)
    total <= (CW+1)'(lldak_pkg::NODE_COUNT))
    else $error("kept and deleted lists overflow the order list");

  // A walk always begins its reads with a rewound read position.
  a_walk_rewound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lldak_pkg::S_NODE_RD || state_r == lldak_pkg::S_UPDATE)
      |-> rpos_r == '0)
    else $error("read position moved during a walk");

  // The epoch never takes the value that marks a cleared seen map entry.
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch aliases cleared seen map entries");

endmodule

[test/linked_list_dedup_abs_key_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for linked_list_dedup_abs_key_unit: loads node tables, walks
// lists and reads back the kept and deleted nodes, checked against a built-in predictor.
// Depends on lldak_pkg and the unit's RTL.
module linked_list_dedup_abs_key_unit_test;
  import lldak_pkg::*;

  localparam int CLOCK_LIMIT     = 4000000;
  localparam int TARGET_REQUESTS = 1900;
  localparam int DRAIN_CYCLES    = 16;
  localparam int READ_CAP        = 40;

  // The request code that the unit ignores.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Link value that ends a list.
  localparam logic [LINK_W-1:0] LINK_END = {LINK_W{1'b1}};

  // One emitted node, kept as raw bits.
  typedef struct packed {
    logic              list_id;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [LINK_W-1:0] next;
    logic              last;
  } node_out_t;

  // How a directed row is checked: by the predictor, as giving no result, or by a typed-in answer.
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NO_RESULT, CHK_TYPED} row_check_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [LINK_W-1:0] link;
    row_check_t        check;
    node_out_t         typed;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [ACT_W-1:0]         in_action;
  logic [ADDR_W-1:0]        in_node_addr;
  logic signed [KEY_W-1:0]  in_node_key;
  logic signed [LINK_W-1:0] in_link_addr;
  logic                     out_valid;
  logic                     out_list_id;
  logic [ADDR_W-1:0]        out_addr;
  logic signed [KEY_W-1:0]  out_key;
  logic signed [LINK_W-1:0] out_next;
  logic                     out_last_of_list;

  // Shadow of the node table, seen map and emit order.
  logic [KEY_W-1:0]         shadow_key [NODE_COUNT];
  logic signed [LINK_W-1:0] shadow_link [NODE_COUNT];
  bit                       shadow_loaded [NODE_COUNT];
  bit                       key_seen [SEEN_SIZE];
  logic [ADDR_W-1:0]        walk_order [NODE_COUNT];
  int unsigned              kept_total;
  int unsigned              deleted_total;
  int unsigned              emit_pos;

  node_out_t   expected_nodes[$];
  stim_row_t   directed[$];
  int unsigned request_count;
  int unsigned error_count;
  int unsigned cycle_count;
  bit          idle_allowed;

  linked_list_dedup_abs_key_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_node_addr     (in_node_addr),
    .in_node_key      (in_node_key),
    .in_link_addr     (in_link_addr),
    .out_valid        (out_valid),
    .out_list_id      (out_list_id),
    .out_addr         (out_addr),
    .out_key          (out_key),
    .out_next         (out_next),
    .out_last_of_list (out_last_of_list)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append a node to the queue of expected results.
  function automatic void expect_node(input node_out_t n);
    expected_nodes.insert(expected_nodes.size(), n);
  endfunction

  // Append a row to the directed stimulus table.
  function automatic void add_row(input stim_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  // Seen map slot of a key: its magnitude, saturated to the last entry.
  function automatic int unsigned seen_slot(logic [KEY_W-1:0] key_bits);
    int mag;
    mag = $signed(key_bits);
    if (mag < 0) mag = -mag;
    if (mag > SEEN_SIZE - 1) mag = SEEN_SIZE - 1;
    return mag;
  endfunction

  // Walk from the head, sorting nodes into the kept list (front of the order
  // store) and the deleted list (back of the order store, growing downwards).
  function automatic void dedup_walk(logic [ADDR_W-1:0] head);
    logic [ADDR_W-1:0] cur;
    int unsigned       steps;
    int unsigned       slot;
    bit                done;
    cur  = head;
    steps = 0;
    done = 1'b0;
    foreach (key_seen[i]) key_seen[i] = 1'b0;
    kept_total    = 0;
    deleted_total = 0;
    emit_pos      = 0;
    while (!done && steps < DEPTH && kept_total + deleted_total < NODE_COUNT) begin
      slot = seen_slot(shadow_key[cur]);
      if (!key_seen[slot]) begin
        key_seen[slot] = 1'b1;
        walk_order[kept_total] = cur;
        kept_total++;
      end else begin
        walk_order[NODE_COUNT - 1 - deleted_total] = cur;
        deleted_total++;
      end
      steps++;
      // Any negative link ends the list.
      if (shadow_link[cur] < 0) done = 1'b1;
      else cur = shadow_link[cur][ADDR_W-1:0];
    end
  endfunction

  // Apply one accepted request to the shadow state; returns 1 when it emits a node.
  function automatic bit predict_request(input logic [ACT_W-1:0] action,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [KEY_W-1:0] key,
                                         input logic [LINK_W-1:0] link,
                                         output node_out_t res);
    int unsigned d;
    res = '0;
    case (action)
      ACT_LOAD: begin
        shadow_key[addr]    = key;
        shadow_link[addr]   = link;
        shadow_loaded[addr] = 1'b1;
        return 1'b0;
      end
      ACT_START: begin
        dedup_walk(addr);
        return 1'b0;
      end
      ACT_READ: begin
        if (emit_pos < kept_total) begin
          res.list_id = 1'b0;
          res.addr    = walk_order[emit_pos];
          res.last    = (emit_pos + 1 >= kept_total);
          res.next    = res.last ? LINK_END : {1'b0, walk_order[emit_pos + 1]};
        end else if (emit_pos < kept_total + deleted_total) begin
          d = emit_pos - kept_total;
          res.list_id = 1'b1;
          res.addr    = walk_order[NODE_COUNT - 1 - d];
          res.last    = (d + 1 >= deleted_total);
          res.next    = res.last ? LINK_END : {1'b0, walk_order[NODE_COUNT - 2 - d]};
        end else begin
          // Past the end of both lists: nothing, and the position holds.
          return 1'b0;
        end
        res.key = shadow_key[res.addr];
        emit_pos++;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // First never-loaded node that a walk from this head would touch, or -1.
  function automatic int first_unloaded_on_path(logic [ADDR_W-1:0] head);
    logic [ADDR_W-1:0] cur;
    cur = head;
    for (int steps = 0; steps < WALK_LIMIT; steps++) begin
      if (!shadow_loaded[cur]) return int'(cur);
      if (shadow_link[cur] < 0) return -1;
      cur = shadow_link[cur][ADDR_W-1:0];
    end
    return -1;
  endfunction

  // A random negative link, from -1 down to -1024.
  function automatic logic [LINK_W-1:0] end_link();
    return LINK_W'(-$urandom_range(1, 1024));
  endfunction

  // Mostly small magnitudes so that duplicates are common, now and then extremes.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    int          mag;
    r = $urandom_range(0, 29);
    if (r == 0) return KEY_W'(4095);
    if (r == 1) return KEY_W'(-4095);
    if (r == 2) return KEY_W'(-4096);
    if (r < 6) return KEY_W'($urandom);
    mag = $urandom_range(0, 9);
    return $urandom_range(0, 1) ? KEY_W'(-mag) : KEY_W'(mag);
  endfunction

  function automatic stim_row_t stim_row(logic [ACT_W-1:0] action, logic [ADDR_W-1:0] addr,
                                         logic [KEY_W-1:0] key, logic [LINK_W-1:0] link,
                                         row_check_t check);
    stim_row_t row;
    row        = '0;
    row.action = action;
    row.addr   = addr;
    row.key    = key;
    row.link   = link;
    row.check  = check;
    return row;
  endfunction

  function automatic stim_row_t read_row(logic list_id, logic [ADDR_W-1:0] addr,
                                         logic [KEY_W-1:0] key, logic [LINK_W-1:0] next,
                                         logic last);
    stim_row_t row;
    row = stim_row(ACT_READ, '0, '0, '0, CHK_TYPED);
    row.typed.list_id = list_id;
    row.typed.addr    = addr;
    row.typed.key     = key;
    row.typed.next    = next;
    row.typed.last    = last;
    return row;
  endfunction

  // Present one request, hold it until the unit takes it, then record what it should give.
  task automatic send_request(input logic [ACT_W-1:0] action, input logic [ADDR_W-1:0] addr,
                              input logic [KEY_W-1:0] key, input logic [LINK_W-1:0] link,
                              input row_check_t check, input node_out_t typed);
    node_out_t predicted;
    bit        produced;
    if (idle_allowed && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= action;
    in_node_addr <= addr;
    in_node_key  <= key;
    in_link_addr <= link;
    do @(posedge clk); while (busy !== 1'b0);
    produced = predict_request(action, addr, key, link, predicted);
    if (action != ACT_UNUSED) request_count++;
    case (check)
      CHK_PREDICT: if (produced) expect_node(predicted);
      CHK_TYPED:   expect_node(typed);
      default:     ;
    endcase
  endtask

  // Unrelated traffic: stray loads, reads and the ignored request code.
  task automatic send_noise();
    logic [ADDR_W-1:0] target;
    logic [LINK_W-1:0] link;
    int unsigned       pick;
    pick   = $urandom_range(0, 9);
    target = ADDR_W'($urandom);
    // Stray links only point at loaded nodes, so walks stay on loaded ground.
    link   = shadow_loaded[target] ? {1'b0, target} : end_link();
    if (pick < 6) begin
      send_request(ACT_LOAD, ADDR_W'($urandom), KEY_W'($urandom), link, CHK_PREDICT, '0);
    end else if (pick < 9) begin
      send_request(ACT_READ, ADDR_W'($urandom), KEY_W'($urandom), LINK_W'($urandom),
                   CHK_PREDICT, '0);
    end else begin
      send_request(ACT_UNUSED, ADDR_W'($urandom), KEY_W'($urandom), LINK_W'($urandom),
                   CHK_PREDICT, '0);
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result checker: every strobed node against the oldest expectation.
  always @(posedge clk) begin
    node_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_nodes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual list %0d addr %0d key %0d",
                 $time, out_list_id, out_addr, out_key);
        error_count++;
      end else begin
        want = expected_nodes.pop_front();
        compare_field("list_id", int'(want.list_id), int'(out_list_id));
        compare_field("addr", int'(want.addr), int'(out_addr));
        compare_field("key", int'($signed(want.key)), int'(out_key));
        compare_field("next", int'($signed(want.next)), int'(out_next));
        compare_field("last_of_list", int'(want.last), int'(out_last_of_list));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CLOCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] chain[$];
    logic [LINK_W-1:0] tail;
    int unsigned       len;
    int unsigned       reads;
    int                miss;
    bit                abandon;

    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_action    <= ACT_LOAD;
    in_node_addr <= '0;
    in_node_key  <= '0;
    in_link_addr <= '0;
    idle_allowed = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first list is 0 -> 1023 -> 5 -> 7 -> 9; keys 4095, -4095
    // and -4096 share the saturated slot, and node 9 ends on a link of -1024.
    add_row(stim_row(ACT_READ, 0, 0, 0, CHK_NO_RESULT));
    add_row(stim_row(ACT_UNUSED, 1023, -1, -1, CHK_NO_RESULT));
    add_row(stim_row(ACT_LOAD, 0, 4095, 1023, CHK_NO_RESULT));
    add_row(stim_row(ACT_LOAD, 1023, -4095, 5, CHK_NO_RESULT));
    add_row(stim_row(ACT_LOAD, 5, -4096, 7, CHK_NO_RESULT));
    add_row(stim_row(ACT_LOAD, 7, 0, 9, CHK_NO_RESULT));
    add_row(stim_row(ACT_LOAD, 9, 0, -1024, CHK_NO_RESULT));
    add_row(stim_row(ACT_START, 0, 0, 0, CHK_NO_RESULT));
    add_row(read_row(1'b0, 0, 4095, 7, 1'b0));
    add_row(read_row(1'b0, 7, 0, LINK_END, 1'b1));
    add_row(read_row(1'b1, 1023, -4095, 5, 1'b0));
    add_row(read_row(1'b1, 5, -4096, 9, 1'b0));
    add_row(read_row(1'b1, 9, 0, LINK_END, 1'b1));
    add_row(stim_row(ACT_READ, 0, 0, 0, CHK_NO_RESULT));
    // A node that links to itself: the walk runs until the step limit.
    add_row(stim_row(ACT_LOAD, 5, 1, 5, CHK_NO_RESULT));
    add_row(stim_row(ACT_START, 5, 0, 0, CHK_NO_RESULT));
    add_row(read_row(1'b0, 5, 1, LINK_END, 1'b1));
    add_row(read_row(1'b1, 5, 1, 5, 1'b0));
    // A new start part-way through reading restarts both lists.
    add_row(stim_row(ACT_START, 7, 0, 0, CHK_NO_RESULT));
    add_row(read_row(1'b0, 7, 0, LINK_END, 1'b1));
    add_row(stim_row(ACT_START, 1023, 0, 0, CHK_PREDICT));
    add_row(stim_row(ACT_READ, 0, 0, 0, CHK_PREDICT));
    // Reloading a node's key shows up in later reads of that node.
    add_row(stim_row(ACT_LOAD, 5, -7, 5, CHK_PREDICT));
    add_row(stim_row(ACT_READ, 0, 0, 0, CHK_PREDICT));
    add_row(stim_row(ACT_READ, 0, 0, 0, CHK_PREDICT));
    foreach (directed[r]) begin
      send_request(directed[r].action, directed[r].addr, directed[r].key, directed[r].link,
                   directed[r].check, directed[r].typed);
    end

    // Random part: build a list, walk it, read it back, with stray requests mixed in.
    while (request_count < TARGET_REQUESTS) begin
      idle_allowed = !(request_count >= 700 && request_count < 1000);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      chain.delete();
      repeat (len) chain.insert(chain.size(), ADDR_W'($urandom));
      abandon = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) begin
          // Now and then the tail links back into the list, making a cycle.
          tail = ($urandom_range(0, 15) == 0) ? {1'b0, chain[$urandom_range(0, len - 1)]}
                                              : end_link();
        end else begin
          tail = {1'b0, chain[i + 1]};
        end
        send_request(ACT_LOAD, chain[i], pick_key(), tail, CHK_PREDICT, '0);
        if ($urandom_range(0, 9) == 0) send_noise();
        if (abandon && i == len / 2) break;
      end
      if (!abandon) begin
        // Make sure the walk only meets loaded nodes.
        miss = first_unloaded_on_path(chain[0]);
        while (miss >= 0) begin
          send_request(ACT_LOAD, ADDR_W'(miss), pick_key(), end_link(), CHK_PREDICT, '0);
          miss = first_unloaded_on_path(chain[0]);
        end
        send_request(ACT_START, chain[0], KEY_W'($urandom), LINK_W'($urandom),
                     CHK_PREDICT, '0);
        reads = kept_total + deleted_total + $urandom_range(0, 2);
        if (reads > READ_CAP) reads = $urandom_range(READ_CAP / 2, READ_CAP);
        repeat (reads) begin
          send_request(ACT_READ, ADDR_W'($urandom), KEY_W'($urandom), LINK_W'($urandom),
                       CHK_PREDICT, '0);
          if ($urandom_range(0, 19) == 0) send_noise();
        end
      end
    end
    start <= 1'b0;

    while (expected_nodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
